### rtl/x86enc_pkg.sv
// x86enc_pkg: field widths, command codes and byte helpers for the x86-64 encoder
// no dependencies; imported by the channel interfaces and the encoder core
`default_nettype none

package x86enc_pkg;

   localparam int CmdWidth   = 6;
   localparam int RegWidth   = 4;
   localparam int ImmWidth   = 64;
   localparam int DispWidth  = 32;
   localparam int ByteWidth  = 8;
   localparam int MaxBytes   = 10;
   localparam int CountWidth = $clog2(MaxBytes + 1);

   typedef logic [CmdWidth-1:0]         cmd_type;
   typedef logic [RegWidth-1:0]         reg_type;
   typedef logic [ImmWidth-1:0]         imm_type;
   typedef logic signed [DispWidth-1:0] disp_type;
   typedef logic [ByteWidth-1:0]        byte_type;
   typedef logic [CountWidth-1:0]       count_type;
   typedef logic [MaxBytes-1:0][ByteWidth-1:0] code_buf_type;

   // instruction forms
   localparam cmd_type CMD_MOV_RR       = 6'd0;
   localparam cmd_type CMD_MOV_RI64     = 6'd1;
   localparam cmd_type CMD_MOV_RM_ABS   = 6'd2;
   localparam cmd_type CMD_MOV_MR_ABS   = 6'd3;
   localparam cmd_type CMD_ADD_RR       = 6'd4;
   localparam cmd_type CMD_SUB_RR       = 6'd5;
   localparam cmd_type CMD_IMUL_RR      = 6'd6;
   localparam cmd_type CMD_CQO          = 6'd7;
   localparam cmd_type CMD_IDIV         = 6'd8;
   localparam cmd_type CMD_CMP_RI32     = 6'd9;
   localparam cmd_type CMD_JLE          = 6'd10;
   localparam cmd_type CMD_JMP          = 6'd11;
   localparam cmd_type CMD_JE           = 6'd12;
   localparam cmd_type CMD_PUSH         = 6'd13;
   localparam cmd_type CMD_POP          = 6'd14;
   localparam cmd_type CMD_CALL         = 6'd15;
   localparam cmd_type CMD_RET          = 6'd16;
   localparam cmd_type CMD_SYSCALL      = 6'd17;
   localparam cmd_type CMD_XOR_RR       = 6'd18;
   localparam cmd_type CMD_INC          = 6'd19;
   localparam cmd_type CMD_DEC          = 6'd20;
   localparam cmd_type CMD_NEG          = 6'd21;
   localparam cmd_type CMD_JNS          = 6'd22;
   localparam cmd_type CMD_TEST_RR      = 6'd23;
   localparam cmd_type CMD_JNZ          = 6'd24;
   localparam cmd_type CMD_JA           = 6'd25;
   localparam cmd_type CMD_JL           = 6'd26;
   localparam cmd_type CMD_JG           = 6'd27;
   localparam cmd_type CMD_JGE          = 6'd28;
   localparam cmd_type CMD_JNE          = 6'd29;
   localparam cmd_type CMD_CMP_RR       = 6'd30;
   localparam cmd_type CMD_ADD_RI8      = 6'd31;
   localparam cmd_type CMD_SUB_RI8      = 6'd32;
   localparam cmd_type CMD_IMUL_RI32    = 6'd33;
   localparam cmd_type CMD_MOV_R8I8     = 6'd34;
   localparam cmd_type CMD_MOVB_ABS_I8  = 6'd35;
   localparam cmd_type CMD_MOV_BL_BASE  = 6'd36;
   localparam cmd_type CMD_MOV_ABS_BL   = 6'd37;
   localparam cmd_type CMD_MOV_ABS_DL   = 6'd38;
   localparam cmd_type CMD_CMP_BL_I8    = 6'd39;
   localparam cmd_type CMD_SUB_BL_I8    = 6'd40;
   localparam cmd_type CMD_ADD_DL_I8    = 6'd41;
   localparam cmd_type CMD_DIV          = 6'd42;
   localparam cmd_type CMD_MOVB_BASE_I8 = 6'd43;
   localparam cmd_type CMD_MOV_BASE_DL  = 6'd44;
   localparam cmd_type CMD_CVTSI2SD     = 6'd45;
   localparam cmd_type CMD_SQRTSD       = 6'd46;
   localparam cmd_type CMD_CVTTSD2SI    = 6'd47;

   // modrm addressing modes
   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP32   = 2'd2;
   localparam logic [1:0] MOD_REGISTER = 2'd3;

   localparam logic [2:0] RM_SIB      = 3'd4;
   localparam logic [2:0] RBP_CODE    = 3'd5;
   localparam byte_type   SIB_ABS     = 8'h25;
   localparam logic [3:0] REX_HIGH    = 4'h4;

   // pack mod:2 reg:3 rm:3
   function automatic byte_type modrm(input logic [1:0] mode, input logic [2:0] regf,
                                      input logic [2:0] rmf);
      return {mode, regf, rmf};
   endfunction

   // REX 0100WRXB with X always clear
   function automatic byte_type rex(input logic w, input logic r, input logic b);
      return {REX_HIGH, w, r, 1'b0, b};
   endfunction

endpackage

`default_nettype wire

### rtl/x86enc_req_if.sv
// x86enc_req_if: request channel carrying one instruction to encode
// depends on x86enc_pkg for field types
`default_nettype none

interface x86enc_req_if;
   import x86enc_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  command;
   reg_type  dst_reg;
   reg_type  src_reg;
   imm_type  immediate;
   disp_type displacement;

   modport source (output valid, output command, output dst_reg, output src_reg,
                   output immediate, output displacement, input ready);
   modport sink   (input valid, input command, input dst_reg, input src_reg,
                   input immediate, input displacement, output ready);
endinterface

`default_nettype wire

### rtl/x86enc_rsp_if.sv
// x86enc_rsp_if: response channel carrying one machine code byte per transaction
// depends on x86enc_pkg for field types
`default_nettype none

interface x86enc_rsp_if;
   import x86enc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type code_byte;
   logic     last_byte;

   modport source (output valid, output code_byte, output last_byte, input ready);
   modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/x86_64_instruction_encoder_core.sv
// x86_64_instruction_encoder_core: x86-64 machine code encoder
// depends on x86enc_pkg, x86enc_req_if and x86enc_rsp_if
//
// Usage
//   req_chan (sink): one instruction per transaction (command, dst_reg, src_reg,
//   immediate, displacement). rsp_chan (source): the encoding, one code_byte per
//   transaction in emission order, last_byte high on the final byte.
//   Commands 48 to 63 produce no bytes at all.
// Flow
//   A request is captured in an input register; the encoding is then built from
//   it and loaded into a byte shift register, which drives rsp_chan. Each
//   instruction has 1 to 10 bytes, sent one per transaction over the single
//   byte-wide response channel. The next request is taken while the current one
//   is still being sent, so instructions follow each other with no gap on
//   rsp_chan. An unused command still passes through the input register and can
//   leave a gap.
// Reset
//   reset (synchronous, active high) empties both the input register and the
//   shift register; no bytes are pending afterwards.
// Stalls
//   While rsp_chan.ready is low the current byte holds. The input register fills
//   and req_chan.ready drops until the shift register can take its contents.
`default_nettype none

module x86_64_instruction_encoder_core (
   input  wire logic clock,
   input  wire logic reset,
   x86enc_req_if.sink   req_chan,
   x86enc_rsp_if.source rsp_chan
);
   import x86enc_pkg::*;

   // input register
   logic     in_valid_ff, in_valid_in;
   cmd_type  in_cmd_ff, in_cmd_in;
   reg_type  in_dst_ff, in_dst_in;
   reg_type  in_src_ff, in_src_in;
   imm_type  in_imm_ff, in_imm_in;
   disp_type in_disp_ff, in_disp_in;

   // output shift register
   logic         out_valid_ff, out_valid_in;
   code_buf_type out_buf_ff, out_buf_in;
   count_type    out_rem_ff, out_rem_in;

   // encoder results
   code_buf_type enc_buf;
   count_type    enc_cnt;

   logic req_fire, rsp_fire, out_free, load;

   logic [2:0] d_lo, s_lo;
   logic       dh, sh;
   logic       disp_short;
   byte_type   rex_sd, rex_ds, rex_d, rex_s, rex_dd;
   byte_type   jcc_op;
   logic       is_jcc;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = out_valid_ff && rsp_chan.ready;
   assign out_free = !out_valid_ff || (rsp_fire && out_rem_ff == count_type'(1));
   assign load     = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   // operand fields
   assign d_lo = in_dst_ff[2:0];
   assign s_lo = in_src_ff[2:0];
   assign dh   = in_dst_ff[3];
   assign sh   = in_src_ff[3];
   assign rex_sd = rex(1'b1, sh, dh);
   assign rex_ds = rex(1'b1, dh, sh);
   assign rex_d  = rex(1'b1, 1'b0, dh);
   assign rex_s  = rex(1'b1, 1'b0, sh);
   assign rex_dd = rex(1'b1, dh, dh);
   // displacement fits a signed byte
   assign disp_short = (&in_disp_ff[DispWidth-1:7]) || !(|in_disp_ff[DispWidth-1:7]);

   // condition opcodes of the rel32 conditional jumps
   always_comb begin
      is_jcc = 1'b1;
      case (in_cmd_ff)
         CMD_JLE:          jcc_op = 8'h8E;
         CMD_JE:           jcc_op = 8'h84;
         CMD_JNS:          jcc_op = 8'h89;
         CMD_JNZ, CMD_JNE: jcc_op = 8'h85;
         CMD_JA:           jcc_op = 8'h87;
         CMD_JL:           jcc_op = 8'h8C;
         CMD_JG:           jcc_op = 8'h8F;
         CMD_JGE:          jcc_op = 8'h8D;
         default: begin
            jcc_op = 8'h00;
            is_jcc = 1'b0;
         end
      endcase
   end

   // encoding of the registered instruction
   always_comb begin
      enc_buf = '0;
      enc_cnt = '0;
      if (is_jcc) begin
         enc_buf[0] = 8'h0F;
         enc_buf[1] = jcc_op;
         enc_buf[5:2] = in_disp_ff;
         enc_cnt = count_type'(6);
      end else begin
         case (in_cmd_ff)
            CMD_MOV_RR, CMD_ADD_RR, CMD_SUB_RR, CMD_TEST_RR: begin
               enc_buf[0] = rex_sd;
               case (in_cmd_ff)
                  CMD_MOV_RR: enc_buf[1] = 8'h89;
                  CMD_ADD_RR: enc_buf[1] = 8'h01;
                  CMD_SUB_RR: enc_buf[1] = 8'h29;
                  default:    enc_buf[1] = 8'h85;
               endcase
               enc_buf[2] = modrm(MOD_REGISTER, s_lo, d_lo);
               enc_cnt = count_type'(3);
            end
            CMD_MOV_RI64: begin
               enc_buf[0] = rex_d;
               enc_buf[1] = 8'hB8 + byte_type'(d_lo);
               enc_buf[9:2] = in_imm_ff;
               enc_cnt = count_type'(10);
            end
            CMD_MOV_RM_ABS, CMD_MOV_MR_ABS: begin
               if (in_cmd_ff == CMD_MOV_RM_ABS) begin
                  enc_buf[0] = rex(1'b1, dh, 1'b0);
                  enc_buf[1] = 8'h8B;
                  enc_buf[2] = modrm(MOD_INDIRECT, d_lo, RM_SIB);
               end else begin
                  enc_buf[0] = rex(1'b1, sh, 1'b0);
                  enc_buf[1] = 8'h89;
                  enc_buf[2] = modrm(MOD_INDIRECT, s_lo, RM_SIB);
               end
               enc_buf[3] = SIB_ABS;
               enc_buf[7:4] = in_disp_ff;
               enc_cnt = count_type'(8);
            end
            CMD_IMUL_RR: begin
               enc_buf[0] = rex_ds;
               enc_buf[1] = 8'h0F;
               enc_buf[2] = 8'hAF;
               enc_buf[3] = modrm(MOD_REGISTER, d_lo, s_lo);
               enc_cnt = count_type'(4);
            end
            CMD_CQO: begin
               enc_buf[0] = rex(1'b1, 1'b0, 1'b0);
               enc_buf[1] = 8'h99;
               enc_cnt = count_type'(2);
            end
            CMD_IDIV, CMD_DIV: begin
               enc_buf[0] = rex_s;
               enc_buf[1] = 8'hF7;
               enc_buf[2] = modrm(MOD_REGISTER, (in_cmd_ff == CMD_IDIV) ? 3'd7 : 3'd6,
                                  s_lo);
               enc_cnt = count_type'(3);
            end
            CMD_CMP_RI32: begin
               enc_buf[0] = rex_d;
               enc_buf[1] = 8'h81;
               enc_buf[2] = modrm(MOD_REGISTER, 3'd7, d_lo);
               enc_buf[6:3] = in_imm_ff[31:0];
               enc_cnt = count_type'(7);
            end
            CMD_JMP, CMD_CALL: begin
               enc_buf[0] = (in_cmd_ff == CMD_JMP) ? 8'hE9 : 8'hE8;
               enc_buf[4:1] = in_disp_ff;
               enc_cnt = count_type'(5);
            end
            CMD_PUSH, CMD_POP: begin
               // rex.b only for r8 to r15
               if (dh) begin
                  enc_buf[0] = rex(1'b0, 1'b0, 1'b1);
                  enc_buf[1] = ((in_cmd_ff == CMD_PUSH) ? 8'h50 : 8'h58) + byte_type'(d_lo);
                  enc_cnt = count_type'(2);
               end else begin
                  enc_buf[0] = ((in_cmd_ff == CMD_PUSH) ? 8'h50 : 8'h58) + byte_type'(d_lo);
                  enc_cnt = count_type'(1);
               end
            end
            CMD_RET: begin
               enc_buf[0] = 8'hC3;
               enc_cnt = count_type'(1);
            end
            CMD_SYSCALL: begin
               enc_buf[0] = 8'h0F;
               enc_buf[1] = 8'h05;
               enc_cnt = count_type'(2);
            end
            CMD_XOR_RR, CMD_CMP_RR: begin
               enc_buf[0] = rex_ds;
               enc_buf[1] = (in_cmd_ff == CMD_XOR_RR) ? 8'h33 : 8'h3B;
               enc_buf[2] = modrm(MOD_REGISTER, d_lo, s_lo);
               enc_cnt = count_type'(3);
            end
            CMD_INC, CMD_DEC, CMD_NEG: begin
               enc_buf[0] = rex_d;
               case (in_cmd_ff)
                  CMD_INC: begin
                     enc_buf[1] = 8'hFF;
                     enc_buf[2] = modrm(MOD_REGISTER, 3'd0, d_lo);
                  end
                  CMD_DEC: begin
                     enc_buf[1] = 8'hFF;
                     enc_buf[2] = modrm(MOD_REGISTER, 3'd1, d_lo);
                  end
                  default: begin
                     enc_buf[1] = 8'hF7;
                     enc_buf[2] = modrm(MOD_REGISTER, 3'd3, d_lo);
                  end
               endcase
               enc_cnt = count_type'(3);
            end
            CMD_ADD_RI8, CMD_SUB_RI8: begin
               enc_buf[0] = rex_d;
               enc_buf[1] = 8'h83;
               enc_buf[2] = modrm(MOD_REGISTER, (in_cmd_ff == CMD_ADD_RI8) ? 3'd0 : 3'd5,
                                  d_lo);
               enc_buf[3] = in_imm_ff[7:0];
               enc_cnt = count_type'(4);
            end
            CMD_IMUL_RI32: begin
               enc_buf[0] = rex_dd;
               enc_buf[1] = 8'h69;
               enc_buf[2] = modrm(MOD_REGISTER, d_lo, d_lo);
               enc_buf[6:3] = in_imm_ff[31:0];
               enc_cnt = count_type'(7);
            end
            CMD_MOV_R8I8: begin
               enc_buf[0] = 8'hB0 + byte_type'(d_lo);
               enc_buf[1] = in_imm_ff[7:0];
               enc_cnt = count_type'(2);
            end
            CMD_MOVB_ABS_I8: begin
               enc_buf[0] = 8'hC6;
               enc_buf[1] = modrm(MOD_INDIRECT, 3'd0, RM_SIB);
               enc_buf[2] = SIB_ABS;
               enc_buf[6:3] = in_disp_ff;
               enc_buf[7] = in_imm_ff[7:0];
               enc_cnt = count_type'(8);
            end
            CMD_MOV_BL_BASE: begin
               // no rex and no sib; mod from the displacement size
               enc_buf[0] = 8'h8A;
               if (in_disp_ff == '0 && in_src_ff != {1'b0, RBP_CODE}) begin
                  enc_buf[1] = modrm(MOD_INDIRECT, 3'd3, s_lo);
                  enc_cnt = count_type'(2);
               end else if (disp_short) begin
                  enc_buf[1] = modrm(MOD_DISP8, 3'd3, s_lo);
                  enc_buf[2] = in_disp_ff[7:0];
                  enc_cnt = count_type'(3);
               end else begin
                  enc_buf[1] = modrm(MOD_DISP32, 3'd3, s_lo);
                  enc_buf[5:2] = in_disp_ff;
                  enc_cnt = count_type'(6);
               end
            end
            CMD_MOV_ABS_BL, CMD_MOV_ABS_DL: begin
               enc_buf[0] = 8'h88;
               enc_buf[1] = modrm(MOD_INDIRECT, (in_cmd_ff == CMD_MOV_ABS_BL) ? 3'd3 : 3'd2,
                                  RM_SIB);
               enc_buf[2] = SIB_ABS;
               enc_buf[6:3] = in_disp_ff;
               enc_cnt = count_type'(7);
            end
            CMD_CMP_BL_I8, CMD_SUB_BL_I8, CMD_ADD_DL_I8: begin
               enc_buf[0] = 8'h80;
               case (in_cmd_ff)
                  CMD_CMP_BL_I8: enc_buf[1] = 8'hFB;
                  CMD_SUB_BL_I8: enc_buf[1] = 8'hEB;
                  default:       enc_buf[1] = 8'hC2;
               endcase
               enc_buf[2] = in_imm_ff[7:0];
               enc_cnt = count_type'(3);
            end
            CMD_MOVB_BASE_I8: begin
               enc_buf[0] = 8'hC6;
               enc_buf[1] = modrm(MOD_INDIRECT, 3'd0, s_lo);
               enc_buf[2] = in_imm_ff[7:0];
               enc_cnt = count_type'(3);
            end
            CMD_MOV_BASE_DL: begin
               enc_buf[0] = 8'h88;
               enc_buf[1] = modrm(MOD_INDIRECT, 3'd2, s_lo);
               enc_cnt = count_type'(2);
            end
            CMD_CVTSI2SD: begin
               enc_buf[0] = 8'hF2;
               enc_buf[1] = rex_s;
               enc_buf[2] = 8'h0F;
               enc_buf[3] = 8'h2A;
               enc_buf[4] = modrm(MOD_REGISTER, 3'd0, s_lo);
               enc_cnt = count_type'(5);
            end
            CMD_SQRTSD: begin
               enc_buf[0] = 8'hF2;
               enc_buf[1] = 8'h0F;
               enc_buf[2] = 8'h51;
               enc_buf[3] = modrm(MOD_REGISTER, 3'd0, 3'd0);
               enc_cnt = count_type'(4);
            end
            CMD_CVTTSD2SI: begin
               enc_buf[0] = 8'hF2;
               enc_buf[1] = rex(1'b1, dh, 1'b0);
               enc_buf[2] = 8'h0F;
               enc_buf[3] = 8'h2C;
               enc_buf[4] = modrm(MOD_REGISTER, d_lo, 3'd0);
               enc_cnt = count_type'(5);
            end
            default: begin
               enc_cnt = '0;
            end
         endcase
      end
   end

   // input register next state
   always_comb begin
      in_cmd_in  = in_cmd_ff;
      in_dst_in  = in_dst_ff;
      in_src_in  = in_src_ff;
      in_imm_in  = in_imm_ff;
      in_disp_in = in_disp_ff;
      in_valid_in = in_valid_ff && !load;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_cmd_in   = req_chan.command;
         in_dst_in   = req_chan.dst_reg;
         in_src_in   = req_chan.src_reg;
         in_imm_in   = req_chan.immediate;
         in_disp_in  = req_chan.displacement;
      end
   end

   // output shift register next state
   always_comb begin
      out_buf_in   = out_buf_ff;
      out_rem_in   = out_rem_ff;
      out_valid_in = out_valid_ff;
      if (rsp_fire) begin
         out_buf_in   = {byte_type'(0), out_buf_ff[MaxBytes-1:1]};
         out_rem_in   = out_rem_ff - count_type'(1);
         out_valid_in = (out_rem_ff != count_type'(1));
      end
      if (load) begin
         // an instruction with no bytes is dropped here
         out_buf_in   = enc_buf;
         out_rem_in   = enc_cnt;
         out_valid_in = (enc_cnt != '0);
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_cmd_ff  <= in_cmd_in;
      in_dst_ff  <= in_dst_in;
      in_src_ff  <= in_src_in;
      in_imm_ff  <= in_imm_in;
      in_disp_ff <= in_disp_in;
      out_buf_ff <= out_buf_in;
      out_rem_ff <= out_rem_in;
   end

   // response channel
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.code_byte = out_buf_ff[0];
   assign rsp_chan.last_byte = (out_rem_ff == count_type'(1));

endmodule

`default_nettype wire
